/* design/assert_macros.svh */
// Assertion macros shared by the design files.
// Each one checks on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: invariant");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

`endif

/* design/pls_pkg.sv */
package pls_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned POS_W           = 7;
  localparam int unsigned CAP_W           = 7;
  localparam int unsigned REQ_W           = 3;
  localparam int unsigned STAT_W          = 3;
  localparam int unsigned SCAN_G          = 8;
  localparam int unsigned PADDR_W         = 3;
  localparam int unsigned PDATA_W         = 32;
  localparam logic [CAP_W-1:0] CAP_RESET  = 7'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT     = 3'd0,
    REQ_REMOVE     = 3'd1,
    REQ_GET        = 3'd2,
    REQ_UPDATE     = 3'd3,
    REQ_FIND       = 3'd4,
    REQ_REMOVE_VAL = 3'd5,
    REQ_CLEAR      = 3'd6
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_BADPOS   = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_NOP = 2'd0,
    OP_INS = 2'd1,
    OP_DEL = 2'd2,
    OP_WR  = 2'd3
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_HOLD = 2'd2
  } fsm_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

  // One result beat.
  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] read_value;
    logic [POS_W-1:0]  found_position;
    logic [POS_W-1:0]  list_length;
  } res_t;

endpackage

/* design/pls_cell.sv */
module pls_cell #(
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CNT_W    = 7,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                      clk,
  input  pls_pkg::cell_cmd_t        cmd,
  input  logic [IDX_W-1:0]          cmd_idx,
  input  logic [CNT_W-1:0]          count,
  input  logic [pls_pkg::DATA_W-1:0] prev_q,
  input  logic [pls_pkg::DATA_W-1:0] next_q,
  output logic [pls_pkg::DATA_W-1:0] q,
  output logic                      match
);
  import pls_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

  logic [DATA_W-1:0] q_r;
  logic [DATA_W-1:0] q_nxt;

  // Insert opens a gap by taking the left neighbor, delete closes one by
  // taking the right neighbor.
  always_comb begin
    q_nxt = q_r;
    case (cmd.op)
      OP_INS: begin
        if (MY_IDX == cmd_idx) begin
          q_nxt = cmd.value;
        end else if (MY_IDX > cmd_idx) begin
          q_nxt = prev_q;
        end
      end
      OP_DEL: begin
        if (MY_IDX >= cmd_idx) begin
          q_nxt = next_q;
        end
      end
      OP_WR: begin
        if (MY_IDX == cmd_idx) begin
          q_nxt = cmd.value;
        end
      end
      default: begin
        q_nxt = q_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q     = q_r;
  assign match = (q_r == cmd.value) && (MY_CNT < count);

endmodule

/* design/pls_scan.sv */
module pls_scan #(
  parameter int unsigned MV_W   = 64,
  parameter int unsigned BASE_W = 6
) (
  input  logic              clk,
  input  logic              load,
  input  logic [MV_W-1:0]   match_in,
  output logic              hit,
  output logic [BASE_W-1:0] hit_pos,
  output logic              last
);
  import pls_pkg::*;

  localparam int unsigned PE_W = $clog2(SCAN_G);

  logic [MV_W-1:0]   match_r;
  logic [MV_W-1:0]   match_nxt;
  logic [BASE_W-1:0] base_r;
  logic [BASE_W-1:0] base_nxt;
  logic [PE_W-1:0]   pe;

  // The match vector moves one group toward bit zero per cycle.
  always_comb begin
    match_nxt = load ? match_in : (match_r >> SCAN_G);
    base_nxt  = load ? '0 : (base_r + BASE_W'(SCAN_G));
  end

  always_ff @(posedge clk) begin
    match_r <= match_nxt;
    base_r  <= base_nxt;
  end

  always_comb begin
    pe = '0;
    for (int i = SCAN_G - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        pe = PE_W'(i);
      end
    end
  end

  assign hit     = |match_r[SCAN_G-1:0];
  assign hit_pos = base_r + BASE_W'(pe);
  assign last    = (base_r == BASE_W'(MV_W - SCAN_G));

endmodule

/* design/positional_list_store.sv */
// Insert, remove, get, update, clear and rejected requests register their result beat on
//   acceptance, find and remove by value when the scan ends, into the hold slot on a stall.
// Throughput: one positional request per cycle unless the output stalls; a value search
//   scans eight cells of its match vector per cycle and holds the input off until it ends.
// Reset (synchronous, rst_n low): length zero, capacity 64, output empty; the entries
//   themselves are not cleared and need no clearing pass.
module positional_list_store #(
  parameter int unsigned MAX_ENTRIES = pls_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Request channel.
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pls_pkg::REQ_W-1:0]        in_req_type,
  input  logic [pls_pkg::POS_W-1:0]        in_position,
  input  logic signed [pls_pkg::DATA_W-1:0] in_value,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pls_pkg::STAT_W-1:0]       out_status,
  output logic signed [pls_pkg::DATA_W-1:0] out_read_value,
  output logic [pls_pkg::POS_W-1:0]        out_found_position,
  output logic [pls_pkg::POS_W-1:0]        out_list_length,
  // Register port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pls_pkg::PADDR_W-1:0]      paddr,
  input  logic [pls_pkg::PDATA_W-1:0]      pwdata,
  output logic [pls_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);
  import pls_pkg::*;

  `include "assert_macros.svh"

  // Widths that follow from the built depth. Positions and counts are compared at
  // CMP_W so that the 7-bit position field and the count never overflow each other.
  localparam int unsigned IDX_W  = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int unsigned NGRP   = (MAX_ENTRIES + SCAN_G - 1) / SCAN_G;
  localparam int unsigned MV_W   = NGRP * SCAN_G;
  localparam int unsigned BASE_W = $clog2(MV_W);

  // Control state.
  fsm_t             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload state.
  res_t             out_r, out_nxt;
  res_t             hold_r, hold_nxt;
  logic             rmv_r, rmv_nxt;

  // Cell chain.
  cell_cmd_t         cmd;
  logic [IDX_W-1:0]  cmd_idx;
  logic [DATA_W-1:0] cell_q [MAX_ENTRIES];
  logic [MV_W-1:0]   match_v;

  // Scan unit.
  logic              scan_load;
  logic              scan_hit;
  logic [BASE_W-1:0] scan_pos;
  logic              scan_last;
  logic [BASE_W:0]   fpos_ext;

  // Request decode helpers.
  logic [CMP_W-1:0]  pos_c, cnt_c, cap_c, max_c, eff_cap;
  logic [IDX_W-1:0]  in_idx;
  logic              out_free;
  logic              produce;
  res_t              res;
  logic              cfg_wr;

  // ---------------------------------------------------------------------------
  // Register port. Capacity lives at byte address 0; the upper address bit
  // selects a slot past the register list, which reads as zero.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[PADDR_W-1];
  assign prdata = paddr[PADDR_W-1] ? '0 : PDATA_W'(cap_r);

  always_comb begin
    cap_nxt = cfg_wr ? pwdata[CAP_W-1:0] : cap_r;
  end

  // ---------------------------------------------------------------------------
  // Chain of cells. Each cell holds one entry, takes its neighbor's entry when
  // the list opens or closes around it, and compares itself with the request
  // value every cycle.
  // ---------------------------------------------------------------------------
  for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
    logic [DATA_W-1:0] prev_q;
    logic [DATA_W-1:0] next_q;

    if (gi == 0) begin : g_first
      assign prev_q = '0;
    end else begin : g_mid_prev
      assign prev_q = cell_q[gi-1];
    end

    if (gi == MAX_ENTRIES - 1) begin : g_last
      assign next_q = cell_q[gi];
    end else begin : g_mid_next
      assign next_q = cell_q[gi+1];
    end

    pls_cell #(
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (gi)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .cmd_idx (cmd_idx),
      .count   (count_r),
      .prev_q  (prev_q),
      .next_q  (next_q),
      .q       (cell_q[gi]),
      .match   (match_v[gi])
    );
  end

  // The match vector is padded up to whole scan groups.
  if (MV_W > MAX_ENTRIES) begin : g_pad
    assign match_v[MV_W-1:MAX_ENTRIES] = '0;
  end

  // The scan unit captures the match vector at acceptance and walks it eight
  // cells a cycle; cells at or beyond the length never report a match.
  pls_scan #(
    .MV_W   (MV_W),
    .BASE_W (BASE_W)
  ) u_scan (
    .clk      (clk),
    .load     (scan_load),
    .match_in (match_v),
    .hit      (scan_hit),
    .hit_pos  (scan_pos),
    .last     (scan_last)
  );

  assign fpos_ext = {1'b0, scan_pos} + (BASE_W + 1)'(1);

  // ---------------------------------------------------------------------------
  // Request decode. Positions are 1-based, so the cell index is position - 1.
  // An insert checks for a full list before it checks the position; remove,
  // get and update check for an empty list first.
  // ---------------------------------------------------------------------------
  assign pos_c   = CMP_W'(in_position);
  assign cnt_c   = CMP_W'(count_r);
  assign cap_c   = CMP_W'(cap_r);
  assign max_c   = CMP_W'(MAX_ENTRIES);
  assign eff_cap = (cap_c > max_c) ? max_c : cap_c;
  assign in_idx  = IDX_W'(pos_c - CMP_W'(1));

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // Datapath and output decisions.
  always_comb begin
    cmd.op             = OP_NOP;
    cmd.value          = in_value;
    cmd_idx            = in_idx;
    count_nxt          = count_r;
    produce            = 1'b0;
    scan_load          = 1'b0;
    rmv_nxt            = rmv_r;
    res.status         = STAT_OK;
    res.read_value     = '1;
    res.found_position = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          produce = 1'b1;
          case (req_t'(in_req_type))
            REQ_INSERT: begin
              if (cnt_c >= eff_cap) begin
                res.status = STAT_FULL;
              end else if (pos_c == '0 || pos_c > cnt_c + CMP_W'(1)) begin
                res.status = STAT_BADPOS;
              end else begin
                cmd.op    = OP_INS;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            REQ_REMOVE, REQ_GET, REQ_UPDATE: begin
              if (count_r == '0) begin
                res.status = STAT_EMPTY;
              end else if (pos_c == '0 || pos_c > cnt_c) begin
                res.status = STAT_BADPOS;
              end else if (req_t'(in_req_type) == REQ_REMOVE) begin
                cmd.op    = OP_DEL;
                count_nxt = count_r - CNT_W'(1);
              end else if (req_t'(in_req_type) == REQ_GET) begin
                res.read_value = cell_q[in_idx];
              end else begin
                cmd.op = OP_WR;
              end
            end
            REQ_FIND, REQ_REMOVE_VAL: begin
              if (count_r == '0) begin
                res.status = STAT_EMPTY;
              end else begin
                produce   = 1'b0;
                scan_load = 1'b1;
                rmv_nxt   = (req_t'(in_req_type) == REQ_REMOVE_VAL);
              end
            end
            REQ_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              res.status = STAT_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd_idx = IDX_W'(scan_pos);
        if (scan_hit) begin
          produce            = 1'b1;
          res.found_position = POS_W'(fpos_ext);
          if (rmv_r) begin
            cmd.op    = OP_DEL;
            count_nxt = count_r - CNT_W'(1);
          end
        end else if (scan_last) begin
          produce    = 1'b1;
          res.status = STAT_NOTFOUND;
        end
      end
      S_HOLD: begin
        produce = 1'b0;
      end
      default: begin
        produce = 1'b0;
      end
    endcase

    res.list_length = POS_W'(count_nxt);
  end

  // Output register with one holding slot behind it: a finished result never
  // stalls the sequencer's decision, it waits in the slot until the output
  // beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    hold_nxt      = hold_r;
    if (state_r == S_HOLD && out_ready) begin
      out_nxt       = hold_r;
      out_valid_nxt = 1'b1;
    end else if (produce) begin
      if (out_free) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        hold_nxt = res;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (scan_load) begin
          state_nxt = S_SCAN;
        end else if (produce && !out_free) begin
          state_nxt = S_HOLD;
        end
      end
      S_SCAN: begin
        if (produce) begin
          state_nxt = out_free ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    hold_r <= hold_nxt;
    rmv_r  <= rmv_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_read_value     = out_r.read_value;
  assign out_found_position = out_r.found_position;
  assign out_list_length    = out_r.list_length;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // The length never runs past the built depth.
  `ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(MAX_ENTRIES))
  // A result parked in the holding slot implies the output register is full.
  `ASSERT_IMPLIES(a_hold_full, state_r == S_HOLD, out_valid_r)
  // Any failing request reports the all-ones read value.
  `ASSERT_IMPLIES(a_err_read, out_valid && out_status != STAT_OK, out_read_value == '1)
  // A reported match position always comes with a good status.
  `ASSERT_IMPLIES(a_found_ok, out_valid && out_found_position != '0, out_status == STAT_OK)

endmodule
